// File: hdl/mmf_pkg.sv
// Shared types and constants of the fixed-point matrix multiplier.
`default_nettype none

package mmf_pkg;

  localparam int ELEM_W      = 16;
  localparam int IDX_W       = 3;
  localparam int DIM_W       = 4;
  localparam int FRAC_W      = 8;
  localparam int PROD_W      = 2 * ELEM_W;
  // eight products of 32 bits each need three more bits of headroom
  localparam int ACC_W       = PROD_W + 3;
  localparam int MAX_DIM_DEF = 8;
  localparam int DIM_LIMIT   = 8;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 4;

  typedef enum logic [1:0] {
    CMD_LOAD_LEFT  = 2'd0,
    CMD_LOAD_RIGHT = 2'd1,
    CMD_COMPUTE    = 2'd2
  } cmd_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_LEFT_ROWS  = 2'd0,
    REG_INNER_SIZE = 2'd1,
    REG_RIGHT_COLS = 2'd2
  } reg_e;

  // control that travels with one multiply-accumulate step
  typedef struct packed {
    logic valid;
    logic first;
    logic lastk;
  } mac_ctl_t;

endpackage

`default_nettype wire

// File: hdl/mmf_if.sv
// Request channel interfaces: input items, result items and register writes.
`default_nettype none

interface mmf_in_if;
  logic                                valid;
  logic                                ready;
  logic [1:0]                          command;
  logic [mmf_pkg::IDX_W-1:0]           row_index;
  logic [mmf_pkg::IDX_W-1:0]           col_index;
  logic signed [mmf_pkg::ELEM_W-1:0]   element;

  modport source (output valid, command, row_index, col_index, element, input ready);
  modport sink   (input valid, command, row_index, col_index, element, output ready);
endinterface

interface mmf_out_if;
  logic                                valid;
  logic                                ready;
  logic [mmf_pkg::IDX_W-1:0]           out_row;
  logic [mmf_pkg::IDX_W-1:0]           out_col;
  logic signed [mmf_pkg::ELEM_W-1:0]   product;
  logic                                last;

  modport source (output valid, out_row, out_col, product, last, input ready);
  modport sink   (input valid, out_row, out_col, product, last, output ready);
endinterface

interface mmf_cfg_if;
  logic                                valid;
  logic                                ready;
  logic [mmf_pkg::CFG_IDX_W-1:0]       index;
  logic [mmf_pkg::CFG_DATA_W-1:0]      data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

// File: hdl/mmf_ram.sv
// Single-port-write, single-port-read element store with registered read data.
`default_nettype none

module mmf_ram #(
  parameter int DEPTH = mmf_pkg::MAX_DIM_DEF * mmf_pkg::MAX_DIM_DEF,
  parameter int AW    = 6,
  parameter int W     = mmf_pkg::ELEM_W
) (
  input  wire logic         clk_i,
  input  wire logic         we_i,
  input  wire logic [AW-1:0] waddr_i,
  input  wire logic [W-1:0] wdata_i,
  input  wire logic [AW-1:0] raddr_i,
  output logic      [W-1:0] rdata_o
);

  logic [W-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

`default_nettype wire

// File: hdl/mmf_mac.sv
// Shared multiply-accumulate unit with Q8.8 truncation and saturation.
`default_nettype none

module mmf_mac (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire mmf_pkg::mac_ctl_t                   ctl_i,
  input  wire logic signed [mmf_pkg::ELEM_W-1:0]   a_i,
  input  wire logic signed [mmf_pkg::ELEM_W-1:0]   b_i,
  output logic                                     done_o,
  output logic signed [mmf_pkg::ELEM_W-1:0]        sum_o
);

  localparam int SH_W = mmf_pkg::ACC_W - mmf_pkg::FRAC_W;

  mmf_pkg::mac_ctl_t                    ctl_q;
  logic signed [mmf_pkg::PROD_W-1:0]    prod_q;
  logic signed [mmf_pkg::ACC_W-1:0]     acc_q;
  logic signed [mmf_pkg::ACC_W-1:0]     prod_ext;
  logic signed [SH_W-1:0]               sh;
  logic                                 hi_any;
  logic                                 hi_all;

  assign prod_ext = mmf_pkg::ACC_W'(prod_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_q  <= '0;
      done_o <= 1'b0;
    end else begin
      ctl_q  <= ctl_i;
      done_o <= ctl_q.valid && ctl_q.lastk;
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= a_i * b_i;
    if (ctl_q.valid) begin
      acc_q <= ctl_q.first ? prod_ext : acc_q + prod_ext;
    end
  end

  // floor shift, then clamp when the bits above the result disagree with the sign
  assign sh     = acc_q[mmf_pkg::ACC_W-1:mmf_pkg::FRAC_W];
  assign hi_any = |sh[SH_W-1:mmf_pkg::ELEM_W-1];
  assign hi_all = &sh[SH_W-1:mmf_pkg::ELEM_W-1];

  always_comb begin
    if (!sh[SH_W-1] && hi_any) begin
      sum_o = {1'b0, {(mmf_pkg::ELEM_W-1){1'b1}}};
    end else if (sh[SH_W-1] && !hi_all) begin
      sum_o = {1'b1, {(mmf_pkg::ELEM_W-1){1'b0}}};
    end else begin
      sum_o = sh[mmf_pkg::ELEM_W-1:0];
    end
  end

endmodule

`default_nettype wire

// File: hdl/matrix_multiply_fixed.sv
// Fixed-point matrix multiplier top level: stores, sequencer and output register.
//
// Channels: in_i takes requests; command load-left or load-right writes one Q8.8
// element at (row_index, col_index) of its store, command compute emits the whole
// product in row-major order on out_o, with last set on the final element.
// cfg_i writes left_rows, inner_size and right_cols (index 0, 1, 2); it is always
// ready and is to be used only while the block is idle.
// A load leaves the block idle, so in_i stays ready for the next request.
// A compute runs one shared multiply-accumulate unit: for each product element
// the sequencer issues inner_size reads, each passing through read, multiply and
// accumulate, and the finished sum is then handed off to the output register.
// in_i is not ready during a run.
// When out_o stalls, the finished element waits in the output register and the
// sequencer holds until it is taken; nothing is dropped.
// Reset clears control state and sets all three dimensions to 1; store contents
// are undefined until loaded.
`default_nettype none

module matrix_multiply_fixed #(
  parameter int MAX_DIM = mmf_pkg::MAX_DIM_DEF
) (
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  mmf_in_if.sink       in_i,
  mmf_out_if.source    out_o,
  mmf_cfg_if.sink      cfg_i
);

  localparam int DEPTH   = MAX_DIM * MAX_DIM;
  localparam int AW      = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int DIM_CAP = (MAX_DIM < mmf_pkg::DIM_LIMIT) ? MAX_DIM : mmf_pkg::DIM_LIMIT;
  localparam int DW      = mmf_pkg::DIM_W;
  localparam int IW      = mmf_pkg::IDX_W;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MAC,
    ST_WAIT,
    ST_EMIT
  } state_e;

  state_e                state_q;
  logic [DW-1:0]         left_rows_q, inner_size_q, right_cols_q;
  logic [DW-1:0]         nr_q, nk_q, nc_q;
  logic [IW-1:0]         i_q, j_q, k_q;
  mmf_pkg::mac_ctl_t     rd_ctl_q;
  mmf_pkg::mac_ctl_t     issue_ctl;

  logic                  in_acc;
  logic                  idx_ok;
  logic                  we_left, we_right;
  logic [AW-1:0]         waddr, raddr_left, raddr_right;
  logic [mmf_pkg::ELEM_W-1:0] rdata_left, rdata_right;
  logic                  mac_done;
  logic signed [mmf_pkg::ELEM_W-1:0] mac_sum;
  logic                  slot_free;
  logic                  col_end, row_end, k_end;

  function automatic logic [mmf_pkg::DIM_W-1:0] clamp_dim(input logic [mmf_pkg::DIM_W-1:0] v);
    logic [mmf_pkg::DIM_W-1:0] r;
    r = v;
    if (v == '0) begin
      r = mmf_pkg::DIM_W'(1);
    end else if (int'(v) > DIM_CAP) begin
      r = mmf_pkg::DIM_W'(DIM_CAP);
    end
    return r;
  endfunction

  assign in_i.ready  = (state_q == ST_IDLE);
  assign cfg_i.ready = 1'b1;
  assign in_acc      = in_i.valid && in_i.ready;

  assign idx_ok   = (int'(in_i.row_index) < MAX_DIM) && (int'(in_i.col_index) < MAX_DIM);
  assign we_left  = in_acc && idx_ok &&
                    (mmf_pkg::cmd_e'(in_i.command) == mmf_pkg::CMD_LOAD_LEFT);
  assign we_right = in_acc && idx_ok &&
                    (mmf_pkg::cmd_e'(in_i.command) == mmf_pkg::CMD_LOAD_RIGHT);
  assign waddr    = AW'(int'(in_i.row_index) * MAX_DIM + int'(in_i.col_index));

  assign raddr_left  = AW'(int'(i_q) * MAX_DIM + int'(k_q));
  assign raddr_right = AW'(int'(k_q) * MAX_DIM + int'(j_q));

  assign k_end   = ({1'b0, k_q} + DW'(1)) == nk_q;
  assign col_end = ({1'b0, j_q} + DW'(1)) == nc_q;
  assign row_end = ({1'b0, i_q} + DW'(1)) == nr_q;

  assign issue_ctl.valid = (state_q == ST_MAC);
  assign issue_ctl.first = (k_q == '0);
  assign issue_ctl.lastk = k_end;

  assign slot_free = !out_o.valid || out_o.ready;

  mmf_ram #(.DEPTH(DEPTH), .AW(AW), .W(mmf_pkg::ELEM_W)) u_left_store (
    .clk_i   (clk_i),
    .we_i    (we_left),
    .waddr_i (waddr),
    .wdata_i (in_i.element),
    .raddr_i (raddr_left),
    .rdata_o (rdata_left)
  );

  mmf_ram #(.DEPTH(DEPTH), .AW(AW), .W(mmf_pkg::ELEM_W)) u_right_store (
    .clk_i   (clk_i),
    .we_i    (we_right),
    .waddr_i (waddr),
    .wdata_i (in_i.element),
    .raddr_i (raddr_right),
    .rdata_o (rdata_right)
  );

  mmf_mac u_mac (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  (rd_ctl_q),
    .a_i    (signed'(rdata_left)),
    .b_i    (signed'(rdata_right)),
    .done_o (mac_done),
    .sum_o  (mac_sum)
  );

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      left_rows_q  <= DW'(1);
      inner_size_q <= DW'(1);
      right_cols_q <= DW'(1);
    end else if (cfg_i.valid && cfg_i.ready) begin
      case (mmf_pkg::reg_e'(cfg_i.index))
        mmf_pkg::REG_LEFT_ROWS:  left_rows_q  <= cfg_i.data;
        mmf_pkg::REG_INNER_SIZE: inner_size_q <= cfg_i.data;
        mmf_pkg::REG_RIGHT_COLS: right_cols_q <= cfg_i.data;
        default: ;
      endcase
    end
  end

  // sequencer and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      rd_ctl_q    <= '0;
      out_o.valid <= 1'b0;
      nr_q        <= DW'(1);
      nk_q        <= DW'(1);
      nc_q        <= DW'(1);
      i_q         <= '0;
      j_q         <= '0;
      k_q         <= '0;
    end else begin
      rd_ctl_q <= issue_ctl;
      // in ST_EMIT a taken result is replaced by the next one below
      if (out_o.valid && out_o.ready && state_q != ST_EMIT) begin
        out_o.valid <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (in_acc && mmf_pkg::cmd_e'(in_i.command) == mmf_pkg::CMD_COMPUTE) begin
            nr_q    <= clamp_dim(left_rows_q);
            nk_q    <= clamp_dim(inner_size_q);
            nc_q    <= clamp_dim(right_cols_q);
            i_q     <= '0;
            j_q     <= '0;
            k_q     <= '0;
            state_q <= ST_MAC;
          end
        end
        ST_MAC: begin
          if (k_end) begin
            state_q <= ST_WAIT;
          end else begin
            k_q <= k_q + IW'(1);
          end
        end
        ST_WAIT: begin
          if (mac_done) begin
            state_q <= ST_EMIT;
          end
        end
        ST_EMIT: begin
          if (slot_free) begin
            out_o.valid   <= 1'b1;
            out_o.out_row <= i_q;
            out_o.out_col <= j_q;
            out_o.product <= mac_sum;
            out_o.last    <= row_end && col_end;
            k_q           <= '0;
            if (col_end) begin
              j_q <= '0;
              if (row_end) begin
                state_q <= ST_IDLE;
              end else begin
                i_q     <= i_q + IW'(1);
                state_q <= ST_MAC;
              end
            end else begin
              j_q     <= j_q + IW'(1);
              state_q <= ST_MAC;
            end
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire
